// ===== rtl/sorted_byte_list_top_assert.svh =====
// assertion macros used by the checker file
`ifndef SORTED_BYTE_LIST_TOP_ASSERT_SVH
`define SORTED_BYTE_LIST_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SBL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbl_pkg.sv =====
`default_nettype none

package sbl_pkg;

  localparam int VAL_W = 8;

  // operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DELETED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
  } sbl_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] entry_count;
  } sbl_out_t;

endpackage

`default_nettype wire

// ===== rtl/sbl_mem.sv =====
`default_nettype none

module sbl_mem import sbl_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_byte_list_top.sv =====
// sorted byte list: a table of up to CAPACITY signed bytes kept in ascending order.
// input beat (in_valid/in_ready, in_data): mode 0 inserts value ahead of the first
// entry not smaller, mode 1 deletes the first entry equal to value.
// result beat (out_valid/out_ready, out_data): status and entry count after the op.
// one item at a time: in_ready is high only while the sequencer is idle.
// the entries sit in a one-port-read, one-port-write ram walked one entry a cycle.
// a full insert or an empty delete skips the walk and goes straight to the result.
// a finished result waits in the output register; if the receiver stalls, the
// sequencer holds its result until that register frees, then goes idle.
// reset (rst_n low, synchronous) empties the table at once; no clearing pass,
// since only entries below the count are ever used.
`default_nettype none

module sorted_byte_list_top import sbl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sbl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sbl_out_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sbl_out_t                out_data_r, out_data_nxt;
  logic                    mode_r, mode_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic [AW-1:0]           i_r, i_nxt;
  logic                    placed_r, placed_nxt;
  logic [VAL_W-1:0]        carry_r, carry_nxt;
  logic [2:0]              status_r, status_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  logic [CW-1:0] i_ext;
  logic          have;
  logic          last_ins;
  logic          last_del;
  logic          hit;
  logic [31:0]   cnt_wide;

  // entry storage; reads run ahead of writes (one address on insert, two on delete), so no overlap
  sbl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // walk position compares
  assign i_ext    = CW'(i_r);
  assign have     = i_ext < count_r;
  assign last_ins = i_ext == count_r;
  assign last_del = i_ext == (count_r - 1'b1);
  assign hit      = $signed(rdata) == value_r;
  assign cnt_wide = 32'(count_r);

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mode_nxt      = mode_r;
    value_nxt     = value_r;
    i_nxt         = i_r;
    placed_nxt    = placed_r;
    carry_nxt     = carry_r;
    status_nxt    = status_r;
    we            = 1'b0;
    waddr         = i_r;
    wdata         = value_r;
    raddr         = '0;
    unique case (state_r)
      S_IDLE: begin
        // accept a beat and start reading entry zero
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          value_nxt  = in_data.value;
          i_nxt      = '0;
          placed_nxt = 1'b0;
          if (in_data.mode == MODE_INSERT && count_r == CAP_CNT) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else if (in_data.mode == MODE_DELETE && count_r == '0) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        raddr = i_r + 1'b1;
        i_nxt = i_r + 1'b1;
        if (mode_r == MODE_INSERT) begin
          // place value at first slot not smaller, then ripple the rest up
          if (!placed_r) begin
            if (!have || value_r <= $signed(rdata)) begin
              we         = 1'b1;
              wdata      = value_r;
              carry_nxt  = rdata;
              placed_nxt = 1'b1;
            end
          end else begin
            we        = 1'b1;
            wdata     = carry_r;
            carry_nxt = rdata;
          end
          if (last_ins) begin
            count_nxt  = count_r + 1'b1;
            status_nxt = ST_INSERTED;
            state_nxt  = S_FIN;
          end
        end else begin
          // find first match, then shift later entries down by one
          if (!placed_r) begin
            if (hit) begin
              placed_nxt = 1'b1;
            end
          end else begin
            we    = 1'b1;
            waddr = i_r - 1'b1;
            wdata = rdata;
          end
          if (last_del) begin
            if (placed_r || hit) begin
              count_nxt  = count_r - 1'b1;
              status_nxt = ST_DELETED;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        // hand result to output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = cnt_wide[4:0];
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    mode_r     <= mode_nxt;
    value_r    <= value_nxt;
    i_r        <= i_nxt;
    placed_r   <= placed_nxt;
    carry_r    <= carry_nxt;
    status_r   <= status_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sbl_checker.sv =====
`default_nettype none
`include "sorted_byte_list_top_assert.svh"

module sbl_checker import sbl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire sbl_out_t out_data
);

  localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

  // a stalled result stays offered
  `SBL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // one item at a time: no beat right after an accepted one
  `SBL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while busy")

  // a full insert reports a full table
  `SBL_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && out_data.status == ST_FULL, out_data.entry_count == CAP_LOW, "full status with count below capacity")

  // an empty delete reports a zero count
  `SBL_ASSERT_NOW(a_empty_count, clk, rst_n, out_valid && out_data.status == ST_EMPTY, out_data.entry_count == 5'd0, "empty status with nonzero count")

  // count never passes capacity
  `SBL_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, CAPACITY > 31 || out_data.entry_count <= CAP_LOW, "entry count above capacity")

endmodule

bind sorted_byte_list_top sbl_checker #(.CAPACITY(CAPACITY)) u_sbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
